// ===== rtl/core/psfd_pkg.sv =====
// Shared constants and types for the pose/sonar frame deframer.
`timescale 1ns / 1ps
package psfd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hCC;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] TAIL_BYTE  = 8'hAA;

  localparam int FRAME_LEN = 27;
  localparam int STORE_LEN = FRAME_LEN - 3;
  localparam int POS_W     = $clog2(FRAME_LEN);

  localparam logic [POS_W-1:0] POS_HDR0 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TAIL = POS_W'(FRAME_LEN - 1);

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic        frame_ok;
    logic [31:0] pos_x_bits;
    logic [31:0] pos_y_bits;
    logic [31:0] heading_bits;
    logic [15:0] dist_a1;
    logic [15:0] dist_a2;
    logic [15:0] dist_b1;
    logic [15:0] dist_b2;
    logic [15:0] dist_c1;
    logic [15:0] dist_c2;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
    logic can_take;
  } skid_stat_t;

endpackage

// ===== rtl/core/psfd_in_if.sv =====
// Byte request channel: valid, ready and one received byte.
`timescale 1ns / 1ps
interface psfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/psfd_out_if.sv =====
// Result request channel: valid, ready and the decoded frame fields.
`timescale 1ns / 1ps
interface psfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [31:0] pos_x_bits;
  logic [31:0] pos_y_bits;
  logic [31:0] heading_bits;
  logic [15:0] dist_a1;
  logic [15:0] dist_a2;
  logic [15:0] dist_b1;
  logic [15:0] dist_b2;
  logic [15:0] dist_c1;
  logic [15:0] dist_c2;

  modport source (output valid, output frame_ok, output pos_x_bits, output pos_y_bits,
                  output heading_bits, output dist_a1, output dist_a2, output dist_b1,
                  output dist_b2, output dist_c1, output dist_c2, input ready);
  modport sink   (input valid, input frame_ok, input pos_x_bits, input pos_y_bits,
                  input heading_bits, input dist_a1, input dist_a2, input dist_b1,
                  input dist_b2, input dist_c1, input dist_c2, output ready);
endinterface

// ===== rtl/core/pose_sonar_frame_deframer_unit.sv =====
// Top level of the pose/sonar frame deframer.
`timescale 1ns / 1ps
// Usage:
//   rx_ch takes one received byte per request. The block hunts for 27-byte
//   frames: 0xCC, 0xAA, twelve bytes of x/y/yaw (LE 32-bit), twelve bytes of
//   six LE 16-bit distances, then a tail byte. Header mismatch drops back to
//   the hunt without a result; the rejected byte is not rechecked as a header.
//   res_ch gives one request per tail byte: frame_ok is 1 for a 0xAA tail
//   (held values reloaded from this frame), else 0 with the old held values.
//   Throughput: one byte per cycle while rx_ch.ready is high, set by the
//   position counter and the update of state at each accepted byte.
//   A tail byte's result is registered into the result or skid register.
//   Stall: a result register plus one skid entry; rx_ch.ready stays high until
//   both hold results, so two frames' results can queue while res_ch stalls.
//   Reset (rst, synchronous): position back to the hunt, held values zero,
//   output queue empty. The payload store needs no reset.
module pose_sonar_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  psfd_in_if.sink    rx_ch,
  psfd_out_if.source res_ch
);

  logic                 acc;
  logic                 push;
  psfd_pkg::result_t    push_data;
  psfd_pkg::skid_stat_t stat;
  psfd_pkg::pos_t       pos;

  assign rx_ch.ready = stat.can_take;
  assign acc         = rx_ch.valid && rx_ch.ready;

  psfd_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .rx_byte (rx_ch.rx_byte),
    .push    (push),
    .res     (push_data),
    .pos     (pos)
  );

  psfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .stat      (stat),
    .res_ch    (res_ch)
  );

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    stat.skid_valid |-> stat.main_valid)
    else $error("skid entry held while result register empty");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= psfd_pkg::POS_TAIL)
    else $error("frame position out of range");

  a_hdr_reject: assert property (@(posedge clk) disable iff (rst)
    (acc && pos == psfd_pkg::POS_HDR0 && rx_ch.rx_byte != psfd_pkg::HDR_FIRST)
    |=> pos == psfd_pkg::POS_HDR0)
    else $error("bad first header byte did not restart hunt");

  a_tail_result: assert property (@(posedge clk) disable iff (rst)
    (acc && pos == psfd_pkg::POS_TAIL && !stat.main_valid
     && rx_ch.rx_byte == psfd_pkg::TAIL_BYTE)
    |=> (res_ch.valid && res_ch.frame_ok))
    else $error("good tail did not give an accepted result");

endmodule

// ===== rtl/core/psfd_tracker.sv =====
// Frame position counter, payload shift store and held pose/distance values.
`timescale 1ns / 1ps
module psfd_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output psfd_pkg::result_t res,
  output psfd_pkg::pos_t    pos
);

  logic [7:0]     store [psfd_pkg::STORE_LEN];
  logic [31:0]    held_pose [3];
  logic [15:0]    held_dist [6];
  psfd_pkg::pos_t pos_next;
  psfd_pkg::pos_t cur;
  logic           tail_ok;
  logic [31:0]    new_pose [3];
  logic [15:0]    new_dist [6];

  // out-of-range position behaves as position 0
  assign cur = (pos > psfd_pkg::POS_TAIL) ? psfd_pkg::POS_HDR0 : pos;

  // store[0] holds frame byte 2 once the body has been shifted in
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      new_pose[i] = {store[4*i+3], store[4*i+2], store[4*i+1], store[4*i]};
    end
    for (int i = 0; i < 6; i++) begin
      new_dist[i] = {store[13+2*i], store[12+2*i]};
    end
  end

  assign tail_ok = (rx_byte == psfd_pkg::TAIL_BYTE);
  assign push    = acc && (cur == psfd_pkg::POS_TAIL);

  always_comb begin
    pos_next = pos;
    if (acc) begin
      if (cur == psfd_pkg::POS_HDR0) begin
        pos_next = (rx_byte == psfd_pkg::HDR_FIRST) ? psfd_pkg::POS_HDR1 : psfd_pkg::POS_HDR0;
      end else if (cur == psfd_pkg::POS_HDR1) begin
        pos_next = (rx_byte == psfd_pkg::HDR_SECOND) ? psfd_pkg::POS_BODY : psfd_pkg::POS_HDR0;
      end else if (cur == psfd_pkg::POS_TAIL) begin
        pos_next = psfd_pkg::POS_HDR0;
      end else begin
        pos_next = cur + psfd_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= psfd_pkg::POS_HDR0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (cur >= psfd_pkg::POS_BODY) && (cur < psfd_pkg::POS_TAIL)) begin
      for (int i = 0; i < psfd_pkg::STORE_LEN - 1; i++) begin
        store[i] <= store[i+1];
      end
      store[psfd_pkg::STORE_LEN-1] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) held_pose[i] <= '0;
      for (int i = 0; i < 6; i++) held_dist[i] <= '0;
    end else if (push && tail_ok) begin
      for (int i = 0; i < 3; i++) held_pose[i] <= new_pose[i];
      for (int i = 0; i < 6; i++) held_dist[i] <= new_dist[i];
    end
  end

  // result carries the values as they stand after this tail
  always_comb begin
    res.frame_ok     = tail_ok;
    res.pos_x_bits   = tail_ok ? new_pose[0] : held_pose[0];
    res.pos_y_bits   = tail_ok ? new_pose[1] : held_pose[1];
    res.heading_bits = tail_ok ? new_pose[2] : held_pose[2];
    res.dist_a1      = tail_ok ? new_dist[0] : held_dist[0];
    res.dist_a2      = tail_ok ? new_dist[1] : held_dist[1];
    res.dist_b1      = tail_ok ? new_dist[2] : held_dist[2];
    res.dist_b2      = tail_ok ? new_dist[3] : held_dist[3];
    res.dist_c1      = tail_ok ? new_dist[4] : held_dist[4];
    res.dist_c2      = tail_ok ? new_dist[5] : held_dist[5];
  end

endmodule

// ===== rtl/core/psfd_out_reg.sv =====
// Result register with one skid entry so the byte side keeps moving under stall.
`timescale 1ns / 1ps
module psfd_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  psfd_pkg::result_t      push_data,
  output psfd_pkg::skid_stat_t   stat,
  psfd_out_if.source             res_ch
);

  logic              main_valid;
  logic              skid_valid;
  psfd_pkg::result_t main_data;
  psfd_pkg::result_t skid_data;
  logic              pop;

  assign pop = main_valid && res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign stat.main_valid = main_valid;
  assign stat.skid_valid = skid_valid;
  assign stat.can_take   = !skid_valid;

  assign res_ch.valid        = main_valid;
  assign res_ch.frame_ok     = main_data.frame_ok;
  assign res_ch.pos_x_bits   = main_data.pos_x_bits;
  assign res_ch.pos_y_bits   = main_data.pos_y_bits;
  assign res_ch.heading_bits = main_data.heading_bits;
  assign res_ch.dist_a1      = main_data.dist_a1;
  assign res_ch.dist_a2      = main_data.dist_a2;
  assign res_ch.dist_b1      = main_data.dist_b1;
  assign res_ch.dist_b2      = main_data.dist_b2;
  assign res_ch.dist_c1      = main_data.dist_c1;
  assign res_ch.dist_c2      = main_data.dist_c2;

endmodule
